// ===== rtl/core/srd_pkg.sv =====
package srd_pkg;

   // Record layout
   localparam logic [3:0] REC_BYTES = 4'd12;
   localparam logic [3:0] COUNT_SAT = 4'd13;
   localparam logic [3:0] CRC_BYTES = 4'd8;
   localparam logic [3:0] POS_VERSION = 4'd4;
   localparam logic [3:0] POS_VOLUME = 4'd5;
   localparam logic [3:0] POS_BRIGHT = 4'd6;
   localparam logic [3:0] POS_MUTE = 4'd7;

   localparam logic [31:0] CRC_POLY = 32'hedb88320;
   localparam logic [31:0] CRC_INIT = 32'hffffffff;

   localparam logic [7:0] VERSION_OK = 8'd1;
   localparam logic [7:0] LEVEL_MAX = 8'd100;
   localparam logic [7:0] BRIGHT_MIN = 8'd10;
   localparam logic [7:0] MUTE_MAX = 8'd1;

   // Status codes, in priority order
   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_LENGTH = 3'd1;
   localparam logic [2:0] ST_MAGIC = 3'd2;
   localparam logic [2:0] ST_VERSION = 3'd3;
   localparam logic [2:0] ST_MUTE = 3'd4;
   localparam logic [2:0] ST_CRC = 3'd5;
   localparam logic [2:0] ST_RANGE = 3'd6;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic       accepted;
      logic [2:0] status;
      logic [6:0] volume;
      logic [6:0] brightness;
      logic       muted;
   } rsp_type;

   // Running record state, a single copy for the record being received
   typedef struct packed {
      logic [31:0] crc;
      logic [3:0]  count;
      logic        magic_bad;
      logic        version_bad;
      logic [7:0]  volume;
      logic [7:0]  brightness;
      logic [7:0]  mute;
      logic [31:0] rx_crc;
   } rec_type;

   localparam rec_type REC_RESET = '{
      crc: CRC_INIT, count: 4'd0, magic_bad: 1'b0, version_bad: 1'b0,
      volume: 8'd0, brightness: 8'd0, mute: 8'd0, rx_crc: 32'd0};

   // Magic "SET1", byte by byte
   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      logic [7:0] m;
      case (idx)
         2'd0: m = 8'h53;
         2'd1: m = 8'h45;
         2'd2: m = 8'h54;
         default: m = 8'h31;
      endcase
      return m;
   endfunction

   // Reflected CRC-32, one byte
   function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/settings_record_decoder.sv =====
// Settings record decoder.
// req channel: one record byte per beat, last_byte set on the final byte.
// rsp channel: one beat per record, sent for the beat that carried last_byte:
//   accepted, status (ok, length, magic, version, mute byte, crc, range) and
//   the decoded volume, brightness and mute flag, all zero when rejected.
// A byte is registered in the input register, then folded into the record
// state (magic/version flags, held fields, byte-wide CRC-32). On the last
// byte the checks run in that same cycle and the result lands in the
// output register, which drives rsp_valid. Throughput is one byte per
// cycle unless a final byte waits on a held result, set by the byte-wide
// CRC update between the input register and the record state.
// When rsp_stall holds a result, non-final bytes keep flowing; a final byte
// waits in the input register and req_stall rises until the result is taken.
// Reset (synchronous) empties both registers and returns the record state
// to its start: CRC all ones, byte count zero, flags and fields cleared.
// Records longer than 12 bytes are reported as a length error.
module settings_record_decoder (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  srd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output srd_pkg::rsp_type rsp_data
);
   import srd_pkg::*;

   logic    s1_valid_ff, s1_valid_in;
   req_type s1_beat_ff, s1_beat_in;
   logic    s1_move, out_free, req_fire;
   rec_type rec_next;

   // Input register drains unless a final byte meets a held result
   assign s1_move = s1_valid_ff && (!s1_beat_ff.last_byte || out_free);
   assign req_stall = s1_valid_ff && !s1_move;
   assign req_fire = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = req_fire || (s1_valid_ff && !s1_move);
      s1_beat_in = req_fire ? req_data : s1_beat_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_beat_ff <= s1_beat_in;
   end

   srd_accum u_accum (
      .clock    (clock),
      .reset    (reset),
      .beat_fire(s1_move),
      .beat     (s1_beat_ff),
      .rec_next (rec_next)
   );

   srd_judge u_judge (
      .clock    (clock),
      .reset    (reset),
      .fire     (s1_move && s1_beat_ff.last_byte),
      .rec      (rec_next),
      .rsp_stall(rsp_stall),
      .out_free (out_free),
      .rsp_valid(rsp_valid),
      .rsp      (rsp_data)
   );

endmodule

// ===== rtl/core/srd_accum.sv =====
module srd_accum (
   input  logic             clock,
   input  logic             reset,
   input  logic             beat_fire,
   input  srd_pkg::req_type beat,
   output srd_pkg::rec_type rec_next
);
   import srd_pkg::*;

   rec_type rec_ff, rec_in;

   // Fold one byte into the record state
   always_comb begin
      rec_next = rec_ff;
      if (rec_ff.count < REC_BYTES) begin
         if (rec_ff.count < CRC_BYTES) begin
            rec_next.crc = crc_byte(rec_ff.crc, beat.data_byte);
         end
         if (rec_ff.count < POS_VERSION) begin
            if (beat.data_byte != magic_byte(rec_ff.count[1:0])) begin
               rec_next.magic_bad = 1'b1;
            end
         end else if (rec_ff.count == POS_VERSION) begin
            if (beat.data_byte != VERSION_OK) begin
               rec_next.version_bad = 1'b1;
            end
         end else if (rec_ff.count == POS_VOLUME) begin
            rec_next.volume = beat.data_byte;
         end else if (rec_ff.count == POS_BRIGHT) begin
            rec_next.brightness = beat.data_byte;
         end else if (rec_ff.count == POS_MUTE) begin
            rec_next.mute = beat.data_byte;
         end else begin
            // little-endian CRC bytes
            rec_next.rx_crc = rec_ff.rx_crc |
               ({24'd0, beat.data_byte} << {rec_ff.count[1:0], 3'd0});
         end
      end
      rec_next.count = (rec_ff.count >= COUNT_SAT) ? COUNT_SAT : rec_ff.count + 4'd1;
   end

   // Start over after the last byte of a record
   always_comb begin
      rec_in = rec_ff;
      if (beat_fire) begin
         rec_in = beat.last_byte ? REC_RESET : rec_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff <= REC_RESET;
      end else begin
         rec_ff <= rec_in;
      end
   end

endmodule

// ===== rtl/core/srd_judge.sv =====
module srd_judge (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  srd_pkg::rec_type rec,
   input  logic             rsp_stall,
   output logic             out_free,
   output logic             rsp_valid,
   output srd_pkg::rsp_type rsp
);
   import srd_pkg::*;

   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;
   logic [2:0] status;
   logic       ok;

   // Checks in priority order
   always_comb begin
      if (rec.count != REC_BYTES) begin
         status = ST_LENGTH;
      end else if (rec.magic_bad) begin
         status = ST_MAGIC;
      end else if (rec.version_bad) begin
         status = ST_VERSION;
      end else if (rec.mute > MUTE_MAX) begin
         status = ST_MUTE;
      end else if (rec.rx_crc != ~rec.crc) begin
         status = ST_CRC;
      end else if (rec.volume > LEVEL_MAX || rec.brightness < BRIGHT_MIN ||
                   rec.brightness > LEVEL_MAX) begin
         status = ST_RANGE;
      end else begin
         status = ST_OK;
      end
   end

   assign ok = (status == ST_OK);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Result register: load on a finished record, hold while stalled
   always_comb begin
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (fire) begin
         rsp_valid_in = 1'b1;
         rsp_in.accepted = ok;
         rsp_in.status = status;
         rsp_in.volume = ok ? rec.volume[6:0] : 7'd0;
         rsp_in.brightness = ok ? rec.brightness[6:0] : 7'd0;
         rsp_in.muted = ok && (rec.mute != 8'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

endmodule

// ===== rtl/core/srd_checker.sv =====
module srd_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input srd_pkg::rsp_type rsp_data
);
   import srd_pkg::*;

   // Held result beat stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // Accepted flag agrees with status
   a_ok_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.accepted == (rsp_data.status == ST_OK))
      else $error("accepted does not match status");

   // Rejected records carry zero fields
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.accepted |->
         rsp_data.volume == 7'd0 && rsp_data.brightness == 7'd0 && !rsp_data.muted)
      else $error("rejected record with nonzero fields");

   // Accepted records are in range
   a_accept_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.accepted |->
         {1'b0, rsp_data.volume} <= LEVEL_MAX &&
         {1'b0, rsp_data.brightness} >= BRIGHT_MIN &&
         {1'b0, rsp_data.brightness} <= LEVEL_MAX)
      else $error("accepted record out of range");

   // No result right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind settings_record_decoder srd_checker u_srd_checker (.*);

// ===== tb/sv/settings_record_decoder_tb.sv =====
`timescale 1ns / 100ps

module settings_record_decoder_tb;
   import srd_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 10;
   localparam logic [31:0] MAGIC_TEXT = "SET1";

   // Running copy of the record state on the sender side
   typedef struct packed {
      logic [31:0] crc;
      logic [3:0]  count;
      logic        magic_err;
      logic        version_err;
      logic [7:0]  vol;
      logic [7:0]  bri;
      logic [7:0]  mute;
      logic [31:0] fcs_rx;
   } frame_state_type;

   localparam frame_state_type FRAME_START =
      '{CRC_INIT, 4'd0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 32'd0};

   // One row of the directed table; crc_fill sends the matching FCS byte
   typedef struct {
      logic [7:0] data;
      logic       last;
      bit         crc_fill;
      bit         typed;
      rsp_type    want;
   } dir_row_type;

   localparam rsp_type NO_RSP = '0;
   localparam rsp_type LEN_ERR = '{1'b0, ST_LENGTH, 7'd0, 7'd0, 1'b0};
   localparam rsp_type MAGIC_ERR = '{1'b0, ST_MAGIC, 7'd0, 7'd0, 1'b0};
   localparam rsp_type GOOD_EDGE = '{1'b1, ST_OK, 7'd100, 7'd10, 1'b1};

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   frame_state_type frame_st = FRAME_START;
   rsp_type         pending_results[$];
   logic [7:0]      frame_q[$];
   dir_row_type     directed_rows[26];
   rsp_type         want_rsp;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int beats_sent = 0;
   int records_checked = 0;
   int fail_count = 0;
   int cycle_count = 0;
   int status_hits[8] = '{default: 0};

   settings_record_decoder dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always #6 clock = ~clock;

   // Reflected CRC-32, one byte, LSB first
   function automatic logic [31:0] crc32_fold(input logic [31:0] acc, input logic [7:0] b);
      logic [31:0] c;
      c = acc ^ {24'd0, b};
      repeat (8) c = {1'b0, c[31:1]} ^ (c[0] ? CRC_POLY : 32'd0);
      return c;
   endfunction

   // Fold one beat into frame_st; returns 1 with the decoded result on the last byte
   function automatic bit decode_byte(input req_type beat, output rsp_type res);
      logic [7:0] b;
      logic [2:0] st;
      logic       ok_rec;
      b = beat.data_byte;
      res = '0;
      if (frame_st.count < REC_BYTES) begin
         if (frame_st.count < CRC_BYTES) frame_st.crc = crc32_fold(frame_st.crc, b);
         if (frame_st.count < POS_VERSION) begin
            if (b != MAGIC_TEXT[8 * (3 - int'(frame_st.count)) +: 8])
               frame_st.magic_err = 1'b1;
         end else if (frame_st.count == POS_VERSION) begin
            if (b != VERSION_OK) frame_st.version_err = 1'b1;
         end else if (frame_st.count == POS_VOLUME) begin
            frame_st.vol = b;
         end else if (frame_st.count == POS_BRIGHT) begin
            frame_st.bri = b;
         end else if (frame_st.count == POS_MUTE) begin
            frame_st.mute = b;
         end else begin
            frame_st.fcs_rx[8 * (int'(frame_st.count) - 8) +: 8] = b;
         end
      end
      // count sticks at 13 for overlong records
      if (frame_st.count < COUNT_SAT) frame_st.count = frame_st.count + 4'd1;
      if (!beat.last_byte) return 1'b0;

      if (frame_st.count != REC_BYTES) st = ST_LENGTH;
      else if (frame_st.magic_err) st = ST_MAGIC;
      else if (frame_st.version_err) st = ST_VERSION;
      else if (frame_st.mute > MUTE_MAX) st = ST_MUTE;
      else if (frame_st.fcs_rx != ~frame_st.crc) st = ST_CRC;
      else if (frame_st.vol > LEVEL_MAX || frame_st.bri < BRIGHT_MIN ||
               frame_st.bri > LEVEL_MAX) st = ST_RANGE;
      else st = ST_OK;

      ok_rec = (st == ST_OK);
      res.accepted = ok_rec;
      res.status = st;
      res.volume = ok_rec ? frame_st.vol[6:0] : 7'd0;
      res.brightness = ok_rec ? frame_st.bri[6:0] : 7'd0;
      res.muted = ok_rec && (frame_st.mute != 8'd0);
      frame_st = FRAME_START;
      return 1'b1;
   endfunction

   // Drive one beat, hold it through stalls, then log the expected result
   task automatic send_beat(input req_type beat, input bit typed, input rsp_type want);
      rsp_type got;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_data <= beat;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
      if (decode_byte(beat, got)) pending_results.push_back(typed ? want : got);
   endtask

   // Records with random in-range fields, many with one or more faults
   // stacked (to exercise priority), plus short, long and noise frames
   task automatic build_record();
      logic [7:0]  body[8];
      logic [31:0] fcs;
      int          len;
      frame_q.delete();
      if ($urandom_range(99) < 8) begin
         len = $urandom_range(1, 16);
         repeat (len) frame_q.push_back(8'($urandom));
         return;
      end
      for (int k = 0; k < 4; k++) body[k] = MAGIC_TEXT[8 * (3 - k) +: 8];
      body[4] = VERSION_OK;
      body[5] = 8'($urandom_range(0, 100));
      body[6] = 8'($urandom_range(10, 100));
      body[7] = 8'($urandom_range(0, 1));
      if ($urandom_range(99) >= 35) begin
         if ($urandom_range(99) < 30) begin
            len = $urandom_range(0, 3);
            body[len] = body[len] ^ 8'($urandom_range(1, 255));
         end
         if ($urandom_range(99) < 30) body[4] = VERSION_OK ^ 8'($urandom_range(1, 255));
         if ($urandom_range(99) < 30) body[7] = 8'($urandom_range(2, 255));
         if ($urandom_range(99) < 30) begin
            case ($urandom_range(2))
               0: body[5] = 8'($urandom_range(101, 255));
               1: body[6] = 8'($urandom_range(0, 9));
               default: body[6] = 8'($urandom_range(101, 255));
            endcase
         end
      end
      fcs = CRC_INIT;
      for (int k = 0; k < 8; k++) fcs = crc32_fold(fcs, body[k]);
      fcs = ~fcs;
      if ($urandom_range(99) < 12) fcs = fcs ^ (32'd1 << $urandom_range(31));
      for (int k = 0; k < 8; k++) frame_q.push_back(body[k]);
      for (int k = 0; k < 4; k++) frame_q.push_back(fcs[8 * k +: 8]);
      // length faults: truncate or pad past the twelfth byte
      len = $urandom_range(99);
      if (len < 10) begin
         len = $urandom_range(1, 11);
         while (frame_q.size() > len) void'(frame_q.pop_back());
      end else if (len < 20) begin
         repeat ($urandom_range(1, 8)) frame_q.push_back(8'($urandom));
      end
   endtask

   task automatic run_phase(input int n_beats);
      int start_cnt;
      start_cnt = beats_sent;
      while (beats_sent - start_cnt < n_beats) begin
         build_record();
         for (int i = 0; i < frame_q.size(); i++)
            send_beat('{frame_q[i], (i == frame_q.size() - 1)}, 1'b0, NO_RSP);
      end
   endtask

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   // Result side: compare each taken beat with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("result beat with no record pending: status %0d", rsp_data.status);
            fail_count++;
         end else begin
            want_rsp = pending_results.pop_front();
            check_field("accepted", want_rsp.accepted, rsp_data.accepted);
            check_field("status", want_rsp.status, rsp_data.status);
            check_field("volume", want_rsp.volume, rsp_data.volume);
            check_field("brightness", want_rsp.brightness, rsp_data.brightness);
            check_field("muted", want_rsp.muted, rsp_data.muted);
            status_hits[rsp_data.status]++;
            records_checked++;
         end
      end
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      directed_rows = '{
         // one-byte records, both flag values of the data bits
         '{8'h00, 1'b1, 1'b0, 1'b1, LEN_ERR},
         '{8'hff, 1'b1, 1'b0, 1'b1, LEN_ERR},
         // good record at the range edges, muted
         '{8'h53, 1'b0, 1'b0, 1'b0, NO_RSP},
         '{8'h45, 1'b0, 1'b0, 1'b0, NO_RSP},
         '{8'h54, 1'b0, 1'b0, 1'b0, NO_RSP},
         '{8'h31, 1'b0, 1'b0, 1'b0, NO_RSP},
         '{8'h01, 1'b0, 1'b0, 1'b0, NO_RSP},
         '{8'd100, 1'b0, 1'b0, 1'b0, NO_RSP},
         '{8'd10, 1'b0, 1'b0, 1'b0, NO_RSP},
         '{8'h01, 1'b0, 1'b0, 1'b0, NO_RSP},
         '{8'h00, 1'b0, 1'b1, 1'b0, NO_RSP},
         '{8'h00, 1'b0, 1'b1, 1'b0, NO_RSP},
         '{8'h00, 1'b0, 1'b1, 1'b0, NO_RSP},
         '{8'h00, 1'b1, 1'b1, 1'b1, GOOD_EDGE},
         // magic, version, mute and range checks fail at once; magic wins
         '{8'hff, 1'b0, 1'b0, 1'b0, NO_RSP},
         '{8'h45, 1'b0, 1'b0, 1'b0, NO_RSP},
         '{8'h54, 1'b0, 1'b0, 1'b0, NO_RSP},
         '{8'h31, 1'b0, 1'b0, 1'b0, NO_RSP},
         '{8'h00, 1'b0, 1'b0, 1'b0, NO_RSP},
         '{8'hff, 1'b0, 1'b0, 1'b0, NO_RSP},
         '{8'h00, 1'b0, 1'b0, 1'b0, NO_RSP},
         '{8'hff, 1'b0, 1'b0, 1'b0, NO_RSP},
         '{8'h00, 1'b0, 1'b1, 1'b0, NO_RSP},
         '{8'h00, 1'b0, 1'b1, 1'b0, NO_RSP},
         '{8'h00, 1'b0, 1'b1, 1'b0, NO_RSP},
         '{8'h00, 1'b1, 1'b1, 1'b1, MAGIC_ERR}
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // phase 1: sender idles lightly, receiver stalls heavily
      send_idle_pct = 13;
      recv_idle_pct = 55;
      for (int i = 0; i < 26; i++) begin
         logic [31:0] fcs_now;
         logic [7:0]  d;
         d = directed_rows[i].data;
         if (directed_rows[i].crc_fill) begin
            fcs_now = ~frame_st.crc;
            d = fcs_now[8 * (int'(frame_st.count) - 8) +: 8];
         end
         send_beat('{d, directed_rows[i].last}, directed_rows[i].typed, directed_rows[i].want);
      end
      run_phase(520);

      // phase 2: roles swapped
      send_idle_pct = 55;
      recv_idle_pct = 13;
      run_phase(530);

      // phase 3: back to back
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_phase(530);
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d record beats; checked %0d results in %0d cycles.",
               beats_sent, records_checked, cycle_count);
      $display("Result mix: ok %0d, length %0d, magic %0d, version %0d,",
               status_hits[ST_OK], status_hits[ST_LENGTH], status_hits[ST_MAGIC],
               status_hits[ST_VERSION]);
      $display("            mute %0d, crc %0d, range %0d",
               status_hits[ST_MUTE], status_hits[ST_CRC], status_hits[ST_RANGE]);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
